@@ hw/rtl/tcpu_pkg.sv @@
// Shared definitions for the tiny CPU instruction step unit.
// Holds the machine sizes, the opcode codes and the word and counter types.
// Depends on nothing; the top level, the checker and the testbench import it.
`timescale 1ns / 1ps

package tcpu_pkg;

    localparam int PROG_WORDS     = 512;
    localparam int DATA_WORDS     = 16;
    localparam int REG_COUNT      = 8;
    localparam int WORD_BITS      = 32;

    localparam int PC_BITS        = $clog2(PROG_WORDS);
    localparam int REG_IDX_BITS   = $clog2(REG_COUNT);
    localparam int DATA_ADDR_BITS = $clog2(DATA_WORDS);
    localparam int OPCODE_BITS    = 4;
    localparam int FIELD_Z_BITS   = 11;
    localparam int BYTES_PER_WORD = 4;
    localparam int BYTE_SHIFT     = $clog2(BYTES_PER_WORD);

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [PC_BITS-1:0]   t_pc;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_LW   = 4'd1,
        OP_ADD  = 4'd2,
        OP_SW   = 4'd3,
        OP_SUB  = 4'd4,
        OP_SIO1 = 4'd5,
        OP_SIO2 = 4'd6,
        OP_SIO3 = 4'd7,
        OP_JMP  = 4'd8,
        OP_BEQZ = 4'd9
    } t_opcode;

endpackage

@@ hw/rtl/tcpu_ram.sv @@
// Generic RAM with one write port and two read ports with registered read data.
// The read data registers load only when the read enable is high.
// Depends on nothing.
`timescale 1ns / 1ps

module tcpu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

@@ hw/rtl/tiny_cpu_instruction_step_unit.sv @@
// Top level of the tiny CPU instruction step unit.
// Uses tcpu_pkg for sizes and opcodes and tcpu_ram for the register file.
// Holds the program counter, the data memory and the halt flag itself.
`timescale 1ns / 1ps

// Usage
// Each transfer on the input channel (i_valid, o_ready) carries one fetched
// instruction; each transfer on the result channel (o_valid, i_ready) carries
// the counter, any emitted register value and the halt flag after it.
// Exactly one result follows every instruction, in order.
// The register file read is started at the input transfer; the instruction then
// executes in the execute stage and its result is registered in the result
// register. One instruction is executed per cycle while the receiver keeps up;
// the rate is set by the single execute stage, with a bypass from the register
// file write port covering a read of a register written in the previous cycle.
// When the receiver stalls, the result register holds its result and the
// execute stage holds the next instruction; o_ready falls only when both are
// full. A synchronous reset clears the counter, the register file valid bits,
// the data memory and the halt flag, and empties both stages.
// After a halt instruction, later instructions change nothing and return the
// held counter with the halt flag set.

module tiny_cpu_instruction_step_unit
    import tcpu_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [OPCODE_BITS-1:0]  i_opcode,
    input  logic [2:0]              i_field_x,
    input  logic [2:0]              i_field_y,
    input  logic [FIELD_Z_BITS-1:0] i_field_z,
    input  logic signed [31:0]      i_in_value,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [8:0]              o_next_pc,
    output logic                    o_out_valid,
    output logic signed [31:0]      o_out_value,
    output logic                    o_halted
);

    logic                    in_fire;
    logic                    ex_adv;
    logic                    in_is_addsub;
    logic [REG_IDX_BITS-1:0] rd_addr_a;
    logic [REG_IDX_BITS-1:0] rd_addr_b;

    logic                    r_ex_valid;
    logic [OPCODE_BITS-1:0]  r_ex_opcode;
    logic [REG_IDX_BITS-1:0] r_ex_x;
    logic [FIELD_Z_BITS-1:0] r_ex_z;
    t_word                   r_ex_in_value;
    logic [REG_IDX_BITS-1:0] r_ex_addr_a;
    logic [REG_IDX_BITS-1:0] r_ex_addr_b;

    logic                    r_fwd_en;
    logic [REG_IDX_BITS-1:0] r_fwd_idx;
    t_word                   r_fwd_data;

    t_pc                     r_pc;
    logic                    r_halt;
    logic [REG_COUNT-1:0]    r_rf_valid;
    t_word                   r_dmem [DATA_WORDS];

    logic                    r_out_valid;
    t_pc                     r_out_pc;
    logic                    r_out_emit;
    t_word                   r_out_value;
    logic                    r_out_halted;

    t_word                   ram_a;
    t_word                   ram_b;
    t_word                   rd_a;
    t_word                   rd_b;
    logic [DATA_ADDR_BITS-1:0] dm_addr;

    t_pc                     n_pc;
    logic                    rf_we_c;
    t_word                   rf_wdata;
    logic                    dm_we_c;
    logic                    emit_valid;
    t_word                   emit_value;
    logic                    set_halt;
    logic                    rf_we;
    logic                    dm_we;

    assign in_fire      = i_valid && o_ready;
    assign ex_adv       = r_ex_valid && (!r_out_valid || i_ready);
    assign o_ready      = !r_ex_valid || ex_adv;
    assign in_is_addsub = (i_opcode == OP_ADD) || (i_opcode == OP_SUB);
    assign rd_addr_a    = in_is_addsub ? i_field_y[REG_IDX_BITS-1:0]
                                       : i_field_x[REG_IDX_BITS-1:0];
    assign rd_addr_b    = i_field_z[REG_IDX_BITS-1:0];

    tcpu_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (REG_COUNT)
    ) u_regfile (
        .i_clk       (i_clk),
        .i_we        (rf_we),
        .i_wr_addr   (r_ex_x),
        .i_wr_data   (rf_wdata),
        .i_rd_en     (in_fire),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (ram_a),
        .o_rd_data_b (ram_b)
    );

    // A register written at the edge that took this instruction is read from
    // the bypass, since the RAM returned its old contents at that edge.
    always_comb begin
        if (r_fwd_en && (r_fwd_idx == r_ex_addr_a)) begin
            rd_a = r_fwd_data;
        end else if (r_rf_valid[r_ex_addr_a]) begin
            rd_a = ram_a;
        end else begin
            rd_a = '0;
        end
        if (r_fwd_en && (r_fwd_idx == r_ex_addr_b)) begin
            rd_b = r_fwd_data;
        end else if (r_rf_valid[r_ex_addr_b]) begin
            rd_b = ram_b;
        end else begin
            rd_b = '0;
        end
    end

    assign dm_addr = r_ex_z[DATA_ADDR_BITS-1:0];

    always_comb begin
        n_pc       = r_pc + t_pc'(1);
        rf_we_c    = 1'b0;
        rf_wdata   = '0;
        dm_we_c    = 1'b0;
        emit_valid = 1'b0;
        emit_value = '0;
        set_halt   = 1'b0;
        if (r_halt) begin
            n_pc = r_pc;
        end else begin
            unique case (r_ex_opcode)
                OP_LW: begin
                    rf_we_c  = 1'b1;
                    rf_wdata = r_dmem[dm_addr];
                end
                OP_ADD: begin
                    rf_we_c  = 1'b1;
                    rf_wdata = rd_a + rd_b;
                end
                OP_SW: begin
                    dm_we_c = 1'b1;
                end
                OP_SUB: begin
                    rf_we_c  = 1'b1;
                    rf_wdata = rd_a - rd_b;
                end
                OP_SIO1: begin
                    rf_we_c  = 1'b1;
                    rf_wdata = r_ex_in_value;
                end
                OP_SIO2: begin
                    emit_valid = 1'b1;
                    emit_value = rd_a;
                end
                OP_SIO3: begin
                    set_halt = 1'b1;
                end
                OP_JMP: begin
                    n_pc = t_pc'(r_ex_z >> BYTE_SHIFT);
                end
                OP_BEQZ: begin
                    if ((r_ex_x == '0) && (rd_a == '0)) begin
                        n_pc = r_pc + t_pc'(2);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign rf_we = ex_adv && rf_we_c;
    assign dm_we = ex_adv && dm_we_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_valid <= 1'b0;
            r_fwd_en   <= 1'b0;
        end else begin
            if (in_fire) begin
                r_ex_valid <= 1'b1;
                r_fwd_en   <= rf_we;
            end else if (ex_adv) begin
                r_ex_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ex_opcode   <= i_opcode;
            r_ex_x        <= i_field_x[REG_IDX_BITS-1:0];
            r_ex_z        <= i_field_z;
            r_ex_in_value <= t_word'(i_in_value);
            r_ex_addr_a   <= rd_addr_a;
            r_ex_addr_b   <= rd_addr_b;
            r_fwd_idx     <= r_ex_x;
            r_fwd_data    <= rf_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= '0;
            r_halt       <= 1'b0;
            r_rf_valid   <= '0;
            r_out_valid  <= 1'b0;
            r_out_halted <= 1'b0;
            for (int i = 0; i < DATA_WORDS; i++) begin
                r_dmem[i] <= '0;
            end
        end else begin
            if (ex_adv) begin
                r_pc         <= n_pc;
                r_halt       <= r_halt || set_halt;
                r_out_valid  <= 1'b1;
                r_out_halted <= r_halt || set_halt;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (rf_we) begin
                r_rf_valid[r_ex_x] <= 1'b1;
            end
            if (dm_we) begin
                r_dmem[dm_addr] <= rd_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ex_adv) begin
            r_out_pc    <= n_pc;
            r_out_emit  <= emit_valid;
            r_out_value <= emit_value;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_next_pc   = r_out_pc;
    assign o_out_valid = r_out_emit;
    assign o_out_value = r_out_value;
    assign o_halted    = r_out_halted;

endmodule

@@ hw/rtl/tcpu_checker.sv @@
// Port-level checker for the tiny CPU instruction step unit, with its bind.
// Watches the result channel over time; imports tcpu_pkg, though its port widths are written out.
`timescale 1ns / 1ps

module tcpu_checker
    import tcpu_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_res_valid,
    input logic               i_res_ready,
    input logic [8:0]         i_next_pc,
    input logic               i_out_valid,
    input logic signed [31:0] i_out_value,
    input logic               i_halted
);

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_next_pc)
            && $stable(i_out_value) && $stable(i_out_valid))
        else $error("A stalled result changed before its transfer.");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_halted |=> i_halted)
        else $error("The halt flag was cleared without a reset.");

    a_no_emit_when_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_halted |-> !i_out_valid)
        else $error("A halted result emitted a value.");

    a_pc_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_ready && i_halted |=>
            !i_res_valid || (i_next_pc == $past(i_next_pc)))
        else $error("The counter moved after the halt.");

    a_quiet_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_out_valid |-> i_out_value == '0)
        else $error("A result without output carried a non-zero value.");

endmodule

bind tiny_cpu_instruction_step_unit tcpu_checker u_tcpu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_valid),
    .i_res_ready (i_ready),
    .i_next_pc   (o_next_pc),
    .i_out_valid (o_out_valid),
    .i_out_value (o_out_value),
    .i_halted    (o_halted)
);

@@ verif/tb_tiny_cpu_instruction_step_unit.sv @@
// Self-checking testbench for the tiny CPU instruction step unit.
// Depends on tcpu_pkg for sizes and opcodes and on the unit's top level as the device under test.
// A behavioural model predicts every result, and each result transfer is checked against it.
`timescale 1ns / 1ps

module tb_tiny_cpu_instruction_step_unit
    import tcpu_pkg::*;
();

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    localparam int MAX_GAP      = 11;
    localparam int RANDOM_ITEMS = 900;
    localparam int CHUNK_ITEMS  = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 1000;

    localparam logic [OPCODE_BITS-1:0] OP_UNUSED_HI = '1;

    typedef struct packed {
        t_pc   next_pc;
        logic  out_valid;
        t_word out_value;
        logic  halted;
    } t_step_result;

    logic                    i_clk      = 1'b0;
    logic                    i_rst_n    = 1'b0;
    logic                    i_valid    = 1'b0;
    logic                    o_ready;
    logic [OPCODE_BITS-1:0]  i_opcode   = '0;
    logic [2:0]              i_field_x  = '0;
    logic [2:0]              i_field_y  = '0;
    logic [FIELD_Z_BITS-1:0] i_field_z  = '0;
    logic signed [31:0]      i_in_value = '0;
    logic                    o_valid;
    logic                    i_ready    = 1'b0;
    logic [8:0]              o_next_pc;
    logic                    o_out_valid;
    logic signed [31:0]      o_out_value;
    logic                    o_halted;

    t_pc          cpu_pc;
    t_word        cpu_regs [REG_COUNT];
    t_word        cpu_mem  [DATA_WORDS];
    logic         cpu_halted;
    t_step_result pending_results [$];
    bit           steady_flow;
    int           fail_count;
    int           instr_count;
    int           results_checked;
    int           outputs_seen;
    int           idle_cycles;

    tiny_cpu_instruction_step_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_field_x   (i_field_x),
        .i_field_y   (i_field_y),
        .i_field_z   (i_field_z),
        .i_in_value  (i_in_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_next_pc   (o_next_pc),
        .o_out_valid (o_out_valid),
        .o_out_value (o_out_value),
        .o_halted    (o_halted)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic t_step_result execute_instruction(
        input logic [OPCODE_BITS-1:0]  op,
        input logic [2:0]              x,
        input logic [2:0]              y,
        input logic [FIELD_Z_BITS-1:0] z,
        input t_word                   value
    );
        t_step_result res;
        logic [REG_IDX_BITS-1:0]   rz;
        logic [DATA_ADDR_BITS-1:0] addr;
        rz   = z[REG_IDX_BITS-1:0];
        addr = z[DATA_ADDR_BITS-1:0];
        res  = '0;
        if (!cpu_halted) begin
            cpu_pc = cpu_pc + 1'b1;
            case (op)
                OP_LW:   cpu_regs[x] = cpu_mem[addr];
                OP_ADD:  cpu_regs[x] = cpu_regs[y] + cpu_regs[rz];
                OP_SW:   cpu_mem[addr] = cpu_regs[x];
                OP_SUB:  cpu_regs[x] = cpu_regs[y] - cpu_regs[rz];
                OP_SIO1: cpu_regs[x] = value;
                OP_SIO2: begin
                    res.out_valid = 1'b1;
                    res.out_value = cpu_regs[x];
                end
                OP_SIO3: cpu_halted = 1'b1;
                OP_JMP:  cpu_pc = t_pc'(z >> BYTE_SHIFT);
                OP_BEQZ: begin
                    if (x == '0 && cpu_regs[0] == '0) begin
                        cpu_pc = cpu_pc + 1'b1;
                    end
                end
                default: ;
            endcase
        end
        res.next_pc = cpu_pc;
        res.halted  = cpu_halted;
        return res;
    endfunction

    task automatic send_instr(
        input logic [OPCODE_BITS-1:0]  op,
        input logic [2:0]              x,
        input logic [2:0]              y,
        input logic [FIELD_Z_BITS-1:0] z,
        input t_word                   value
    );
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_opcode   <= op;
        i_field_x  <= x;
        i_field_y  <= y;
        i_field_z  <= z;
        i_in_value <= value;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        pending_results.push_back(execute_instruction(op, x, y, z, value));
        instr_count++;
    endtask

    initial begin : result_checker
        int           stall;
        t_step_result want;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (o_valid !== 1'b1) @(posedge i_clk);
            if (pending_results.size() == 0) begin
                $error("Result transfer arrived with no instruction pending.");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_out_valid === 1'b1) outputs_seen++;
                if (o_next_pc !== want.next_pc) begin
                    $error("next_pc: expected %0d, got %0d", want.next_pc, o_next_pc);
                    fail_count++;
                end
                if (o_out_valid !== want.out_valid) begin
                    $error("out_valid: expected %0b, got %0b", want.out_valid, o_out_valid);
                    fail_count++;
                end
                if (o_out_value !== want.out_value) begin
                    $error("out_value: expected %h, got %h", want.out_value, o_out_value);
                    fail_count++;
                end
                if (o_halted !== want.halted) begin
                    $error("halted: expected %0b, got %0b", want.halted, o_halted);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a transfer.", idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic test_reset_state();
        send_instr(OP_SIO2, 3'd7, 3'd0, '0, '0);
    endtask

    task automatic test_register_ops();
        send_instr(OP_SIO1, 3'd1, 3'd0, '0, 32'h7FFF_FFFF);
        send_instr(OP_SIO1, 3'd2, 3'd0, '0, 32'h8000_0000);
        send_instr(OP_SIO1, 3'd3, 3'd7, '1, 32'hFFFF_FFFF);
        send_instr(OP_ADD,  3'd4, 3'd1, 11'h7F9, '0);
        send_instr(OP_SUB,  3'd5, 3'd2, 11'h001, '0);
        send_instr(OP_SIO2, 3'd4, 3'd0, '0, '0);
        send_instr(OP_SIO2, 3'd5, 3'd0, '0, '0);
    endtask

    task automatic test_memory_ops();
        send_instr(OP_SW,   3'd3, 3'd0, '1, '0);
        send_instr(OP_LW,   3'd6, 3'd0, 11'h00F, '0);
        send_instr(OP_LW,   3'd7, 3'd0, '0, '1);
        send_instr(OP_SIO2, 3'd6, 3'd0, '0, '0);
        send_instr(OP_SIO2, 3'd7, 3'd0, '0, '0);
    endtask

    task automatic test_branch_ops();
        send_instr(OP_BEQZ,      3'd0, 3'd0, '0, '0);
        send_instr(OP_BEQZ,      3'd3, 3'd0, '0, '0);
        send_instr(OP_SIO1,      3'd0, 3'd0, '0, 32'd5);
        send_instr(OP_BEQZ,      3'd0, 3'd0, '0, '0);
        send_instr(OP_JMP,       3'd0, 3'd0, '1, '0);
        send_instr(OP_UNUSED_HI, 3'd7, 3'd7, '1, '1);
        send_instr(OP_SIO1,      3'd0, 3'd0, '0, '0);
        send_instr(OP_JMP,       3'd0, 3'd0, 11'd2040, '0);
        send_instr(OP_BEQZ,      3'd0, 3'd0, '0, '0);
    endtask

    task automatic test_random_programs();
        int                      pick;
        logic [OPCODE_BITS-1:0]  op;
        logic [2:0]              x;
        logic [FIELD_Z_BITS-1:0] z;
        t_word                   value;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady_flow = ((n / CHUNK_ITEMS) % 3 == 2);
            pick  = $urandom_range(0, 99);
            x     = 3'($urandom_range(0, REG_COUNT - 1));
            z     = FIELD_Z_BITS'($urandom);
            value = $urandom;
            if (pick < 12)      op = OP_LW;
            else if (pick < 24) op = OP_ADD;
            else if (pick < 34) op = OP_SW;
            else if (pick < 44) op = OP_SUB;
            else if (pick < 60) op = OP_SIO1;
            else if (pick < 78) op = OP_SIO2;
            else if (pick < 84) op = OP_JMP;
            else if (pick < 94) op = OP_BEQZ;
            else                op = OPCODE_BITS'($urandom_range(OP_BEQZ + 1, 2 ** OPCODE_BITS));
            if (op == OP_BEQZ && $urandom_range(0, 3) != 0) x = '0;
            case ($urandom_range(0, 9))
                0:       value = '0;
                1:       value = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                default: ;
            endcase
            send_instr(op, x, 3'($urandom), z, value);
        end
        steady_flow = 1'b0;
    endtask

    task automatic test_halt();
        send_instr(OP_SIO3, 3'd0, 3'd0, '0, '0);
        send_instr(OP_SIO2, 3'd4, 3'd0, '0, '0);
        send_instr(OP_JMP,  3'd0, 3'd0, '0, '0);
    endtask

    initial begin : stimulus
        cpu_pc      = '0;
        cpu_halted  = 1'b0;
        steady_flow = 1'b0;
        fail_count  = 0;
        foreach (cpu_regs[i]) cpu_regs[i] = '0;
        foreach (cpu_mem[i])  cpu_mem[i]  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_register_ops();
        test_memory_ops();
        test_branch_ops();
        test_random_programs();
        test_halt();
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived.", pending_results.size());
            fail_count++;
        end

        $display("Executed %0d instructions covering every opcode, counter wrap and halt.",
                 instr_count);
        $display("Checked %0d result transfers, %0d of them register outputs.",
                 results_checked, outputs_seen);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
